@@ sv/rgs_pkg.sv @@
// ----------------------------------------------------------------------------
// rgs_pkg
// Types, register indexes and decode tables shared by the rotary switch bank
// scanner and its code decoder.
// ----------------------------------------------------------------------------
package rgs_pkg;

   // Hardware limit on switch pairs in one scan, set by the 3-bit pair index.
   localparam int PAIR_LIMIT = 8;

   typedef enum logic [1:0] {
      SW_TYPE_16POS   = 2'd0,
      SW_TYPE_12POS   = 2'd1,
      SW_TYPE_8POS    = 2'd2,
      SW_TYPE_UNKNOWN = 2'd3
   } sw_type_type;

   typedef enum logic {
      CSR_NUM_PAIRS    = 1'b0,
      CSR_SWITCH_TYPES = 1'b1
   } csr_index_type;

   // Position for each 4-bit code of a 12-position switch; unlisted codes give 0.
   localparam logic [3:0] TWELVE_TAB [16] = '{
      4'd0, 4'd11, 4'd7, 4'd8, 4'd3, 4'd0, 4'd4, 4'd0,
      4'd1, 4'd10, 4'd6, 4'd9, 4'd2, 4'd0, 4'd5, 4'd0
   };

   // Position for each 4-bit code of an 8-position switch; unlisted codes give 0.
   localparam logic [3:0] EIGHT_TAB [16] = '{
      4'd0, 4'd0, 4'd7, 4'd6, 4'd1, 4'd0, 4'd4, 4'd5,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd0, 4'd3, 4'd0
   };

endpackage

@@ sv/rgs_decode.sv @@
// ----------------------------------------------------------------------------
// rgs_decode
// Decodes one 4-bit switch code into a position according to the switch type.
// ----------------------------------------------------------------------------
module rgs_decode
   import rgs_pkg::*;
(
   input  logic [3:0]  code,
   input  sw_type_type sw_type,
   output logic [3:0]  position
);

   logic [3:0] gray_bin;

   // Standard Gray-to-binary: each bit is the XOR of itself and all higher bits.
   assign gray_bin = code ^ (code >> 1) ^ (code >> 2) ^ (code >> 3);

   always_comb begin
      case (sw_type)
         SW_TYPE_16POS: position = gray_bin;
         SW_TYPE_12POS: position = TWELVE_TAB[code];
         SW_TYPE_8POS:  position = EIGHT_TAB[code];
         default:       position = 4'd0;
      endcase
   end

endmodule

@@ sv/rotary_gray_switch_bank_scan.sv @@
// ----------------------------------------------------------------------------
// rotary_gray_switch_bank_scan
// Decodes bytes shifted in from a bank of rotary switches, tracks the stored
// positions and reports whether any switch moved over a scan.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while the result side does not stall and
// gives one result transaction per byte. A byte is first held in the input
// register; decode, compare against the stored positions and update of those
// positions then go in the same cycle into the result register. Throughput is
// set by that one stage, which reads and writes the stored-position row of the
// current pair in the same cycle, so one byte per cycle is sustained while the
// result side is ready. Stored positions reset to "unknown", so the first scan
// after reset always reports a change. MAX_SWITCHES caps the pairs per scan at
// min(8, MAX_SWITCHES/2), and at least 1.
module rotary_gray_switch_bank_scan
   import rgs_pkg::*;
#(
   parameter int MAX_SWITCHES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_shifted_byte,
   input  logic        req_start_scan,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_pair_index,
   output logic [3:0]  rsp_first_position,
   output logic [3:0]  rsp_second_position,
   output logic        rsp_scan_done,
   output logic        rsp_any_change,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int HALF_SW  = MAX_SWITCHES / 2;
   localparam int PAIR_CAP = (HALF_SW > PAIR_LIMIT) ? PAIR_LIMIT :
                             ((HALF_SW < 1) ? 1 : HALF_SW);
   localparam int PAIR_W   = (PAIR_CAP > 1) ? $clog2(PAIR_CAP) : 1;

   // Configuration registers
   logic [3:0]  num_pairs_ff;
   logic [31:0] switch_types_ff;
   logic        csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   // Registers sit on 4-byte boundaries; the byte offset bits are ignored.
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_pairs_ff    <= 4'd8;
         switch_types_ff <= 32'd0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NUM_PAIRS:    num_pairs_ff    <= csr_pwdata[3:0];
            CSR_SWITCH_TYPES: switch_types_ff <= csr_pwdata;
            default:          ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_NUM_PAIRS:    csr_prdata = {28'd0, num_pairs_ff};
         CSR_SWITCH_TYPES: csr_prdata = switch_types_ff;
         default:          csr_prdata = 32'd0;
      endcase
   end

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       proc_go;
   logic       rsp_valid_ff;

   assign proc_go   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | proc_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_shifted_byte;
         in_start_ff <= req_start_scan;
      end
   end

   // Scan state
   logic [PAIR_W-1:0] byte_cnt_ff;
   logic [PAIR_W-1:0] byte_cnt_in;
   logic              change_seen_ff;
   logic              change_seen_in;
   logic [4:0]        stored_ff [PAIR_CAP][2];

   logic [PAIR_W-1:0] pair;
   logic [3:0]        pair_n_raw;
   logic [3:0]        pair_n;
   logic [3:0]        pair_next;
   logic              last;
   logic              seen_prev;
   logic              change_now;
   logic [3:0]        pos_first;
   logic [3:0]        pos_second;
   logic [3:0]        pair_types;

   // A start byte abandons any partial scan before it is handled.
   assign pair      = in_start_ff ? '0 : byte_cnt_ff;
   assign seen_prev = in_start_ff ? 1'b0 : change_seen_ff;

   assign pair_n_raw = (num_pairs_ff == 4'd0) ? 4'd1 : num_pairs_ff;
   assign pair_n     = (pair_n_raw > 4'(PAIR_CAP)) ? 4'(PAIR_CAP) : pair_n_raw;
   assign pair_next  = 4'(pair) + 4'd1;
   assign last       = (pair_next >= pair_n);

   assign pair_types = switch_types_ff[4 * 3'(pair) +: 4];

   rgs_decode u_dec_first (
      .code     (in_byte_ff[7:4]),
      .sw_type  (sw_type_type'(pair_types[1:0])),
      .position (pos_first)
   );

   rgs_decode u_dec_second (
      .code     (in_byte_ff[3:0]),
      .sw_type  (sw_type_type'(pair_types[3:2])),
      .position (pos_second)
   );

   assign change_now = ({1'b0, pos_first}  != stored_ff[pair][0]) |
                       ({1'b0, pos_second} != stored_ff[pair][1]);

   assign byte_cnt_in    = last ? '0 : PAIR_W'(pair_next);
   assign change_seen_in = last ? 1'b0 : (seen_prev | change_now);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff    <= '0;
         change_seen_ff <= 1'b0;
      end else if (proc_go) begin
         byte_cnt_ff    <= byte_cnt_in;
         change_seen_ff <= change_seen_in;
      end
   end

   // Positions reset to all ones, which no decoded position can equal.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAIR_CAP; i++) begin
            stored_ff[i][0] <= 5'h1F;
            stored_ff[i][1] <= 5'h1F;
         end
      end else if (proc_go) begin
         stored_ff[pair][0] <= {1'b0, pos_first};
         stored_ff[pair][1] <= {1'b0, pos_second};
      end
   end

   // Result register
   logic [2:0] rsp_pair_ff;
   logic [3:0] rsp_first_ff;
   logic [3:0] rsp_second_ff;
   logic       rsp_done_ff;
   logic       rsp_change_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go) begin
         rsp_pair_ff   <= 3'(pair);
         rsp_first_ff  <= pos_first;
         rsp_second_ff <= pos_second;
         rsp_done_ff   <= last;
         rsp_change_ff <= last & (seen_prev | change_now);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pair_index      = rsp_pair_ff;
   assign rsp_first_position  = rsp_first_ff;
   assign rsp_second_position = rsp_second_ff;
   assign rsp_scan_done       = rsp_done_ff;
   assign rsp_any_change      = rsp_change_ff;

   // The pair counter never runs past the configured cap.
   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      int'(byte_cnt_ff) < PAIR_CAP)
      else $error("pair counter beyond pair cap");

   // A change is only reported with the last transaction of a scan.
   a_change_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_any_change |-> rsp_scan_done)
      else $error("change reported before end of scan");

   // A held input byte stays in the input register until it is processed.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc_go |=> in_valid_ff)
      else $error("input byte dropped while stalled");

   // Finishing a scan restarts the pair count and the change flag.
   a_scan_restart: assert property (@(posedge clock) disable iff (reset)
      proc_go && last |=> byte_cnt_ff == '0 && !change_seen_ff)
      else $error("scan state not cleared after last byte");

endmodule

@@ tb/rotary_gray_switch_bank_scan_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_gray_switch_bank_scan_tb
// Self-checking bench for the rotary switch bank scanner. A queue-fed driver
// sends shifted bytes in bursts, a monitor stalls the result channel on its
// own pattern, and each accepted byte is run through a bench-side model of
// the decode tables, stored positions and scan counter. Each result is
// checked against the oldest prediction. Directed scans cover every switch
// type and the corner cases. Random phases under changing register settings
// follow.
// ----------------------------------------------------------------------------
module rotary_gray_switch_bank_scan_tb;
   import rgs_pkg::*;

   localparam int RESET_CYCLES   = 7;
   localparam int SWITCH_COUNT   = 16;
   localparam int MAX_SCAN_PAIRS = 8;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 150;
   localparam int REPORT_LIMIT   = 10;
   localparam int DRAIN_CYCLES   = 10;

   // Decode tables kept apart from the package so that a table error shows up.
   localparam logic [3:0] POS_12 [16] = '{
      4'd0, 4'd11, 4'd7, 4'd8, 4'd3, 4'd0, 4'd4, 4'd0,
      4'd1, 4'd10, 4'd6, 4'd9, 4'd2, 4'd0, 4'd5, 4'd0
   };
   localparam logic [3:0] POS_8 [16] = '{
      4'd0, 4'd0, 4'd7, 4'd6, 4'd1, 4'd0, 4'd4, 4'd5,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd2, 4'd0, 4'd3, 4'd0
   };

   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_PATTERN
   } ready_mode_type;

   typedef struct packed {
      logic [7:0] shifted_byte;
      logic       start_scan;
   } scan_byte_type;

   typedef struct packed {
      logic [2:0] pair_index;
      logic [3:0] first_position;
      logic [3:0] second_position;
      logic       scan_done;
      logic       any_change;
   } scan_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_shifted_byte = '0;
   logic        req_start_scan = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_pair_index;
   logic [3:0]  rsp_first_position;
   logic [3:0]  rsp_second_position;
   logic        rsp_scan_done;
   logic        rsp_any_change;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Bench copy of the scanner state and registers.
   logic [4:0]  stored_pos [SWITCH_COUNT];
   logic [2:0]  pair_counter;
   logic        change_flag;
   logic [3:0]  cfg_num_pairs;
   logic [31:0] cfg_switch_types;

   scan_byte_type   pending_bytes [$];
   scan_result_type expected_results [$];
   scan_byte_type   next_item;
   int              burst_left = 1;
   int              idle_left = 0;
   ready_mode_type  ready_mode = READY_ALWAYS;
   int              ready_mode_left = 0;
   logic [15:0]     ready_pattern = 16'h1;
   int              fail_count = 0;

   rotary_gray_switch_bank_scan u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_shifted_byte    (req_shifted_byte),
      .req_start_scan      (req_start_scan),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pair_index      (rsp_pair_index),
      .rsp_first_position  (rsp_first_position),
      .rsp_second_position (rsp_second_position),
      .rsp_scan_done       (rsp_scan_done),
      .rsp_any_change      (rsp_any_change),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [3:0] decode_position(logic [3:0] code, sw_type_type kind);
      case (kind)
         SW_TYPE_16POS: return code ^ (code >> 1) ^ (code >> 2) ^ (code >> 3);
         SW_TYPE_12POS: return POS_12[code];
         SW_TYPE_8POS:  return POS_8[code];
         default:       return 4'd0;
      endcase
   endfunction

   function automatic int scan_pairs();
      int n;
      n = (cfg_num_pairs == 4'd0) ? 1 : int'(cfg_num_pairs);
      return (n > MAX_SCAN_PAIRS) ? MAX_SCAN_PAIRS : n;
   endfunction

   task automatic predict_scan_result(input logic [7:0] shifted_byte, input logic start_scan);
      logic [3:0]      pos [2];
      logic [3:0]      sw;
      logic            last;
      scan_result_type res;
      if (start_scan) begin
         pair_counter = 3'd0;
         change_flag = 1'b0;
      end
      for (int k = 0; k < 2; k++) begin
         sw = {pair_counter, k[0]};
         pos[k] = decode_position((k == 0) ? shifted_byte[7:4] : shifted_byte[3:0],
                                  sw_type_type'(cfg_switch_types[2 * sw +: 2]));
         if ({1'b0, pos[k]} != stored_pos[sw]) change_flag = 1'b1;
         stored_pos[sw] = {1'b0, pos[k]};
      end
      // A counter at or past the last pair closes the scan.
      last = (int'(pair_counter) + 1 >= scan_pairs());
      res = '{pair_counter, pos[0], pos[1], last, last & change_flag};
      expected_results.push_back(res);
      if (last) begin
         pair_counter = 3'd0;
         change_flag = 1'b0;
      end else begin
         pair_counter = pair_counter + 3'd1;
      end
   endtask

   task automatic report_mismatch(input string what, input scan_result_type want,
                                  input scan_result_type got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%s: expected pair=%0d first=%0d second=%0d done=%b change=%b",
                  what, want.pair_index, want.first_position, want.second_position,
                  want.scan_done, want.any_change);
         $display("   got pair=%0d first=%0d second=%0d done=%b change=%b",
                  got.pair_index, got.first_position, got.second_position,
                  got.scan_done, got.any_change);
      end
   endtask

   // Byte driver: bursts of random length with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_scan_result(req_shifted_byte, req_start_scan);
         if (!req_valid || req_ready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               next_item = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_shifted_byte <= next_item.shifted_byte;
               req_start_scan <= next_item.start_scan;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with its own stall pattern.
   always @(posedge clock) begin
      scan_result_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_pair_index, rsp_first_position, rsp_second_position,
                    rsp_scan_done, rsp_any_change};
            if (expected_results.size() == 0)
               report_mismatch("result transaction with none expected", '0, got);
            else if (got !== expected_results[0])
               report_mismatch("result mismatch", expected_results.pop_front(), got);
            else
               void'(expected_results.pop_front());
         end
         if (ready_mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            ready_mode_left = $urandom_range(20, 200);
            ready_pattern = 16'($urandom) | 16'h1;
         end else begin
            ready_mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: begin
               rsp_ready <= ready_pattern[0];
               ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            end
         endcase
      end
   end

   task automatic send(input logic [7:0] shifted_byte, input logic start_scan);
      pending_bytes.push_back('{shifted_byte, start_scan});
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == CSR_NUM_PAIRS) cfg_num_pairs = value[3:0];
      else cfg_switch_types = value;
      @(negedge clock);
   endtask

   task automatic random_phase();
      logic [7:0] prev_scan [MAX_SCAN_PAIRS];
      int         sent;
      int         pairs;
      int         len;
      int         flip;
      logic [7:0] b;
      sent = 0;
      pairs = scan_pairs();
      for (int i = 0; i < MAX_SCAN_PAIRS; i++) prev_scan[i] = 8'($urandom);
      while (sent < PHASE_ITEMS) begin
         case ($urandom_range(0, 9))
            7: begin
               // Scan cut short before its last byte, or at times sent in full.
               len = $urandom_range(1, pairs);
               for (int i = 0; i < len; i++) send(8'($urandom), i == 0);
               sent += len;
            end
            8, 9: begin
               len = $urandom_range(1, 4);
               for (int i = 0; i < len; i++) send(8'($urandom), 1'($urandom_range(0, 1)));
               sent += len;
            end
            default: begin
               // Repeating the last scan exercises the no-change report.
               if ($urandom_range(0, 1) == 0) begin
                  flip = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 8 * pairs - 1);
                  for (int i = 0; i < pairs; i++) begin
                     b = prev_scan[i];
                     if (flip >= 0 && flip / 8 == i) b[flip % 8] = ~b[flip % 8];
                     prev_scan[i] = b;
                     send(b, i == 0);
                  end
               end else begin
                  for (int i = 0; i < pairs; i++) begin
                     prev_scan[i] = 8'($urandom);
                     send(prev_scan[i], i == 0);
                  end
               end
               sent += pairs;
            end
         endcase
      end
   endtask

   initial begin
      logic [31:0] value;
      for (int i = 0; i < SWITCH_COUNT; i++) stored_pos[i] = 5'h1F;
      pair_counter = 3'd0;
      change_flag = 1'b0;
      cfg_num_pairs = 4'd8;
      cfg_switch_types = 32'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Power-on settings: every Gray code once through 16-position switches.
      for (int i = 0; i < 8; i++) send({4'(2 * i), 4'(2 * i + 1)}, i == 0);
      wait_idle();

      // Mixed types, a repeated scan with no change, and a restart mid-scan.
      csr_write(CSR_NUM_PAIRS, 32'd2);
      csr_write(CSR_SWITCH_TYPES, 32'hE4E4_E4E4);
      send(8'h00, 1'b1);
      send(8'hFF, 1'b0);
      send(8'h00, 1'b1);
      send(8'hFF, 1'b0);
      send(8'h5A, 1'b1);
      send(8'hA5, 1'b1);
      send(8'h3C, 1'b0);
      wait_idle();

      // A pair count of zero acts as one.
      csr_write(CSR_NUM_PAIRS, 32'd0);
      send(8'h7E, 1'b0);
      send(8'h7E, 1'b0);
      wait_idle();

      // Count above the cap, then lowered below the counter in mid-scan.
      csr_write(CSR_NUM_PAIRS, 32'd15);
      send(8'h12, 1'b1);
      send(8'h34, 1'b0);
      send(8'h56, 1'b0);
      wait_idle();
      csr_write(CSR_NUM_PAIRS, 32'd2);
      send(8'h78, 1'b0);
      wait_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0:       value = 32'd0;
            1:       value = 32'd1;
            2:       value = 32'd8;
            3:       value = 32'd15;
            default: value = $urandom_range(0, 15);
         endcase
         csr_write(CSR_NUM_PAIRS, value);
         case ($urandom_range(0, 5))
            0:       value = 32'h0000_0000;
            1:       value = 32'hFFFF_FFFF;
            2:       value = 32'h5555_5555;
            3:       value = 32'hAAAA_AAAA;
            default: value = $urandom;
         endcase
         csr_write(CSR_SWITCH_TYPES, value);
         random_phase();
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
